>>> rtl/core/quadratic_root_solver_defines.svh
// Assertion macros shared by the quadratic root solver RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs assertion failed");
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs assertion failed");
`else
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/qrs_pkg.sv
// Shared widths, codes and types of the quadratic root solver.
// No dependencies; imported by every module of the block.
package qrs_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_BITS   = 32;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int DISC_BITS  = PROD_BITS + 3;
    localparam int DMAG_BITS  = PROD_BITS + 1;
    localparam int SQRT_BITS  = (DMAG_BITS + 1) / 2;
    localparam int SQ_BITS    = 2 * SQRT_BITS;
    localparam int BASE_BITS  = WORD_BITS + 1;
    localparam int NUM_BITS   = SQRT_BITS + 2;
    localparam int NMAG_BITS  = NUM_BITS - 1;
    localparam int DMAGD_BITS = WORD_BITS + 1;
    localparam int DIVD_BITS  = NMAG_BITS + FRAC_BITS + 2;
    localparam int DIVR_BITS  = DMAGD_BITS + 1;
    localparam int DCMP_BITS  = DIVR_BITS + WORD_BITS;
    localparam int DIV_LAT    = WORD_BITS + 3;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [PADDR_BITS-3:0] REG_TOL = '0;
    localparam logic [TOL_BITS-1:0]   TOL_RESET = 32'd4295;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_INF  = 2'd3
    } count_t;

    typedef struct packed {
        count_t                        cls;
        logic                          aneg;
        logic signed [BASE_BITS-1:0]   base;
        logic signed [BASE_BITS-1:0]   den;
        logic [DMAG_BITS-1:0]          dmag;
    } job_t;

    typedef struct packed {
        count_t                        cls;
        logic                          aneg;
        logic signed [BASE_BITS-1:0]   base;
        logic signed [BASE_BITS-1:0]   den;
    } sq_tag_t;

    typedef struct packed {
        count_t cls;
        logic   aneg;
    } tag_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

>>> rtl/core/qrs_front.sv
// Front end: registers the coefficients, forms the discriminant and classifies
// each equation into a job for the back end. Depends on qrs_pkg.
module qrs_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]    coef_a,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]    coef_b,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]    coef_c,
    input  logic [qrs_pkg::TOL_BITS-1:0]            tol,
    input  qrs_pkg::fifo_stat_t                     fifo_stat,
    output logic                                    push,
    output qrs_pkg::job_t                           job
);
    import qrs_pkg::*;

    logic fe;
    logic s1_valid_reg, s2_valid_reg;
    logic signed [WORD_BITS-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [PROD_BITS-1:0] bb_reg, ac_reg;
    logic signed [WORD_BITS-1:0] a2_reg, b2_reg, c2_reg;
    logic signed [DISC_BITS-1:0] disc_reg;
    logic signed [DISC_BITS-1:0] disc_next;
    logic signed [DISC_BITS-1:0] ac_ext;
    logic signed [DISC_BITS-1:0] tol_ext;
    logic signed [BASE_BITS-1:0] b_ext, c_ext, neg_b, neg_c, two_a;
    logic ge_tol, in_band;

    assign fe       = !s2_valid_reg || !fifo_stat.full;
    assign in_stall = !fe;
    assign push     = s2_valid_reg && !fifo_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (fe)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        ac_ext    = {{(DISC_BITS-PROD_BITS){ac_reg[PROD_BITS-1]}}, ac_reg};
        disc_next = {{(DISC_BITS-PROD_BITS){bb_reg[PROD_BITS-1]}}, bb_reg}
                    - {ac_ext[DISC_BITS-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            c1_reg   <= coef_c;
            bb_reg   <= coef_b * coef_b;
            ac_reg   <= coef_a * coef_c;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            disc_reg <= disc_next;
        end
    end

    // A negative discriminant still counts as one root when it lies within
    // the tolerance band, so both bounds are checked on the signed value.
    always_comb
    begin
        tol_ext = {{(DISC_BITS-TOL_BITS){1'b0}}, tol};
        ge_tol  = disc_reg >= tol_ext;
        in_band = (disc_reg < tol_ext) && (disc_reg > -tol_ext);
        b_ext   = {b2_reg[WORD_BITS-1], b2_reg};
        c_ext   = {c2_reg[WORD_BITS-1], c2_reg};
        neg_b   = '0 - b_ext;
        neg_c   = '0 - c_ext;
        two_a   = {a2_reg, 1'b0};

        job.aneg = a2_reg[WORD_BITS-1];
        job.dmag = disc_reg[DMAG_BITS-1:0];
        job.base = neg_b;
        job.den  = two_a;
        job.cls  = CNT_NONE;
        priority if (a2_reg == '0)
        begin
            job.base = neg_c;
            job.den  = b_ext;
            if (b2_reg != '0)
                job.cls = CNT_ONE;
            else if (c2_reg == '0)
                job.cls = CNT_INF;
            else
                job.cls = CNT_NONE;
        end
        else if (ge_tol)
            job.cls = CNT_TWO;
        else if (in_band)
            job.cls = CNT_ONE;
        else
            job.cls = CNT_NONE;
    end

endmodule

>>> rtl/core/qrs_fifo.sv
// Short job queue between the front end and the back end.
// Depends on qrs_pkg and the assertion macro header.
`include "quadratic_root_solver_defines.svh"
module qrs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qrs_pkg::job_t       wr_job,
    input  logic                pop,
    output qrs_pkg::job_t       rd_job,
    output qrs_pkg::fifo_stat_t stat
);
    import qrs_pkg::*;

    localparam logic [FIFO_CNT_BITS-1:0] CNT_FULL = FIFO_CNT_BITS'(FIFO_DEPTH);

    job_t                     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;

    assign rd_job     = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == CNT_FULL;
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    `QRS_ASSERT_IMP(a_push_has_room, clk, rst_n, push, count_reg != CNT_FULL)
    `QRS_ASSERT_IMP(a_pop_has_data, clk, rst_n, pop, count_reg != '0)

endmodule

>>> rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage, carrying the job tag.
// Depends on qrs_pkg.
module qrs_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  qrs_pkg::sq_tag_t                in_tag,
    input  logic [qrs_pkg::DMAG_BITS-1:0]   in_val,
    output logic                            out_valid,
    output qrs_pkg::sq_tag_t                out_tag,
    output logic [qrs_pkg::SQRT_BITS-1:0]   out_root
);
    import qrs_pkg::*;

    logic [SQ_BITS-1:0] op_reg  [SQRT_BITS];
    logic [SQ_BITS-1:0] res_reg [SQRT_BITS];
    sq_tag_t            tag_reg [SQRT_BITS];
    logic               vld_reg [SQRT_BITS];

    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_stage
        localparam logic [SQ_BITS-1:0] BIT_K = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * k);
        logic [SQ_BITS-1:0] op_d, res_d, trial, op_q, res_q;
        logic               vld_d;
        sq_tag_t            tag_d;

        if (k == 0)
        begin : g_in
            assign op_d  = {1'b0, in_val};
            assign res_d = '0;
            assign vld_d = in_valid;
            assign tag_d = in_tag;
        end
        else
        begin : g_chain
            assign op_d  = op_reg[k-1];
            assign res_d = res_reg[k-1];
            assign vld_d = vld_reg[k-1];
            assign tag_d = tag_reg[k-1];
        end

        always_comb
        begin
            trial = res_d + BIT_K;
            if (op_d >= trial)
            begin
                op_q  = op_d - trial;
                res_q = (res_d >> 1) + BIT_K;
            end
            else
            begin
                op_q  = op_d;
                res_q = res_d >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_d;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[k]  <= op_q;
                res_reg[k] <= res_q;
                tag_reg[k] <= tag_d;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_BITS-1];
    assign out_tag   = tag_reg[SQRT_BITS-1];
    assign out_root  = res_reg[SQRT_BITS-1][SQRT_BITS-1:0];

endmodule

>>> rtl/core/qrs_div.sv
// Pipelined rounding divider: quotient of num * 2^FRAC_BITS by den, rounded
// half away from zero and clamped to the word range. Depends on qrs_pkg.
module qrs_div (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [qrs_pkg::NUM_BITS-1:0]     num,
    input  logic signed [qrs_pkg::BASE_BITS-1:0]    den,
    output logic [qrs_pkg::WORD_BITS-1:0]           quo,
    output logic                                    sat
);
    import qrs_pkg::*;

    logic [NMAG_BITS-1:0]  nm_reg;
    logic [DMAGD_BITS-1:0] dm_reg;
    logic                  nega_reg;
    logic [NUM_BITS-1:0]   num_abs;
    logic [BASE_BITS-1:0]  den_abs;

    logic [DIVD_BITS-1:0]  dvd_reg;
    logic [DIVR_BITS-1:0]  dvr_reg;
    logic                  negb_reg;

    logic [DIVD_BITS-1:0]  rem_reg [WORD_BITS];
    logic [WORD_BITS-1:0]  q_reg   [WORD_BITS];
    logic [DIVR_BITS-1:0]  dv_reg  [WORD_BITS];
    logic                  big_reg [WORD_BITS];
    logic                  neg_reg [WORD_BITS];

    logic [WORD_BITS-1:0]  limit, mag;
    logic                  sat_d;

    always_comb
    begin
        num_abs = num[NUM_BITS-1] ? ('0 - num) : num;
        den_abs = den[BASE_BITS-1] ? ('0 - den) : den;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_reg   <= num_abs[NMAG_BITS-1:0];
            dm_reg   <= den_abs;
            nega_reg <= num[NUM_BITS-1] ^ den[BASE_BITS-1];
            // Adding half the doubled divisor rounds the quotient to nearest.
            dvd_reg  <= DIVD_BITS'({nm_reg, {(FRAC_BITS+1){1'b0}}}) + DIVD_BITS'(dm_reg);
            dvr_reg  <= {dm_reg, 1'b0};
            negb_reg <= nega_reg;
        end
    end

    for (genvar j = 0; j < WORD_BITS; j++)
    begin : g_step
        localparam int SH = WORD_BITS - 1 - j;
        logic [DIVD_BITS-1:0] rem_d, rem_q;
        logic [WORD_BITS-1:0] q_d, q_q;
        logic [DIVR_BITS-1:0] dv_d;
        logic                 big_d, neg_d;
        logic [DCMP_BITS-1:0] cand, rem_w;

        if (j == 0)
        begin : g_in
            // Any quotient bit above the word means the result saturates.
            assign rem_d = dvd_reg;
            assign q_d   = '0;
            assign dv_d  = dvr_reg;
            assign neg_d = negb_reg;
            assign big_d = DCMP_BITS'(dvd_reg) >= (DCMP_BITS'(dvr_reg) << WORD_BITS);
        end
        else
        begin : g_chain
            assign rem_d = rem_reg[j-1];
            assign q_d   = q_reg[j-1];
            assign dv_d  = dv_reg[j-1];
            assign neg_d = neg_reg[j-1];
            assign big_d = big_reg[j-1];
        end

        always_comb
        begin
            cand  = DCMP_BITS'(dv_d) << SH;
            rem_w = DCMP_BITS'(rem_d);
            rem_q = rem_d;
            q_q   = q_d;
            if (rem_w >= cand)
            begin
                rem_q     = DIVD_BITS'(rem_w - cand);
                q_q[SH]   = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_q;
                q_reg[j]   <= q_q;
                dv_reg[j]  <= dv_d;
                big_reg[j] <= big_d;
                neg_reg[j] <= neg_d;
            end
        end
    end

    always_comb
    begin
        limit = {1'b0, {(WORD_BITS-1){1'b1}}} + WORD_BITS'(neg_reg[WORD_BITS-1]);
        sat_d = big_reg[WORD_BITS-1] || (q_reg[WORD_BITS-1] > limit);
        mag   = sat_d ? limit : q_reg[WORD_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo <= neg_reg[WORD_BITS-1] ? ('0 - mag) : mag;
            sat <= sat_d;
        end
    end

endmodule

>>> rtl/core/quadratic_root_solver.sv
// Path: an accepted equation passes the front end, the queue, the square root, the
// numerator registers, the dividers and the output register. Throughput: one equation
// per cycle while the output is not stalled; the square root and both dividers are
// fully pipelined. A stalled output freezes the back end; the queue keeps the front going.
// Reset: asynchronous, active low; clears all valid state and sets the
// tolerance register to 4295.
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [qrs_pkg::PADDR_BITS-1:0]          paddr,
    input  logic [qrs_pkg::PDATA_BITS-1:0]          pwdata,
    output logic [qrs_pkg::PDATA_BITS-1:0]          prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]    coef_a,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]    coef_b,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]    coef_c,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              root_count,
    output logic signed [qrs_pkg::WORD_BITS-1:0]    root_low,
    output logic signed [qrs_pkg::WORD_BITS-1:0]    root_high,
    output logic                                    saturated
);
    import qrs_pkg::*;

    logic [TOL_BITS-1:0] tol_reg;
    logic                adv;
    logic                push, pop;
    job_t                wr_job, rd_job;
    fifo_stat_t          fstat;

    sq_tag_t             sq_in_tag, sq_out_tag;
    logic [DMAG_BITS-1:0] sq_in_val;
    logic                sq_out_valid;
    logic [SQRT_BITS-1:0] sq_root;

    logic                        nv_reg;
    tag_t                        ntag_reg;
    logic signed [NUM_BITS-1:0]  n0_reg, n1_reg;
    logic signed [BASE_BITS-1:0] den_reg;
    logic signed [NUM_BITS-1:0]  base_ext, root_ext;

    logic                 tl_valid_reg [DIV_LAT];
    tag_t                 tl_tag_reg   [DIV_LAT];

    logic [WORD_BITS-1:0] q0, q1;
    logic                 sat0, sat1;

    logic                 out_valid_reg;
    count_t               count_reg, count_next;
    logic [WORD_BITS-1:0] low_reg, low_next, high_reg, high_next;
    logic                 sat_reg, sat_next;
    tag_t                 last_tag;
    logic                 has_root;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_BITS-1:2] == REG_TOL) ? PDATA_BITS'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (psel && penable && pwrite && pready && (paddr[PADDR_BITS-1:2] == REG_TOL))
            tol_reg <= pwdata[TOL_BITS-1:0];
    end

    assign adv = !out_valid_reg || !out_stall;
    assign pop = !fstat.empty && adv;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .tol       (tol_reg),
        .fifo_stat (fstat),
        .push      (push),
        .job       (wr_job)
    );

    qrs_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .stat   (fstat)
    );

    // Only two-root jobs need the square root; the rest pass a zero through.
    always_comb
    begin
        sq_in_tag.cls  = rd_job.cls;
        sq_in_tag.aneg = rd_job.aneg;
        sq_in_tag.base = rd_job.base;
        sq_in_tag.den  = rd_job.den;
        sq_in_val      = (rd_job.cls == CNT_TWO) ? rd_job.dmag : '0;
    end

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pop),
        .in_tag    (sq_in_tag),
        .in_val    (sq_in_val),
        .out_valid (sq_out_valid),
        .out_tag   (sq_out_tag),
        .out_root  (sq_root)
    );

    always_comb
    begin
        base_ext = {{(NUM_BITS-BASE_BITS){sq_out_tag.base[BASE_BITS-1]}}, sq_out_tag.base};
        root_ext = {{(NUM_BITS-SQRT_BITS){1'b0}}, sq_root};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else if (adv)
            nv_reg <= sq_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n0_reg        <= base_ext - root_ext;
            n1_reg        <= base_ext + root_ext;
            den_reg       <= sq_out_tag.den;
            ntag_reg.cls  <= sq_out_tag.cls;
            ntag_reg.aneg <= sq_out_tag.aneg;
        end
    end

    qrs_div u_div_low (
        .clk (clk),
        .en  (adv),
        .num (n0_reg),
        .den (den_reg),
        .quo (q0),
        .sat (sat0)
    );

    qrs_div u_div_high (
        .clk (clk),
        .en  (adv),
        .num (n1_reg),
        .den (den_reg),
        .quo (q1),
        .sat (sat1)
    );

    for (genvar t = 0; t < DIV_LAT; t++)
    begin : g_tag
        logic vld_d;
        tag_t tag_d;

        if (t == 0)
        begin : g_in
            assign vld_d = nv_reg;
            assign tag_d = ntag_reg;
        end
        else
        begin : g_chain
            assign vld_d = tl_valid_reg[t-1];
            assign tag_d = tl_tag_reg[t-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tl_valid_reg[t] <= 1'b0;
            else if (adv)
                tl_valid_reg[t] <= vld_d;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                tl_tag_reg[t] <= tag_d;
        end
    end

    assign last_tag = tl_tag_reg[DIV_LAT-1];

    // With a negative leading coefficient the minus-root quotient is the larger one.
    always_comb
    begin
        count_next = last_tag.cls;
        low_next   = '0;
        high_next  = '0;
        sat_next   = 1'b0;
        unique case (last_tag.cls)
            CNT_TWO:
            begin
                low_next  = last_tag.aneg ? q1 : q0;
                high_next = last_tag.aneg ? q0 : q1;
                sat_next  = sat0 || sat1;
            end
            CNT_ONE:
            begin
                low_next = q0;
                sat_next = sat0;
            end
            CNT_NONE, CNT_INF:
            begin
                low_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= tl_valid_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root_count = count_reg;
    assign root_low   = low_reg;
    assign root_high  = high_reg;
    assign saturated  = sat_reg;
    assign has_root   = (count_reg == CNT_ONE) || (count_reg == CNT_TWO);

    `QRS_ASSERT_IMP(a_high_unused, clk, rst_n, out_valid_reg && (count_reg != CNT_TWO), high_reg == '0)
    `QRS_ASSERT_IMP(a_sat_has_root, clk, rst_n, out_valid_reg && sat_reg, has_root)
    `QRS_ASSERT_NXT(a_tail_frozen, clk, rst_n, !adv, $stable(tl_valid_reg[DIV_LAT-1]))

endmodule
